// ----- rtl/core/cascaded_position_speed_pi_control_unit_assert.svh -----
// Assertion macros for the cascaded position / speed PI control unit.
// Expects the including module to have the clock i_clk and the reset i_rst_n.
`ifndef CASCADED_POSITION_SPEED_PI_CONTROL_UNIT_ASSERT_SVH
`define CASCADED_POSITION_SPEED_PI_CONTROL_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPSPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPSPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cpspc_pkg.sv -----
// Package for the cascaded position / speed PI control unit.
// Holds widths, fixed-point constants, codes, the sequencer states and helpers.
// No dependencies.
`default_nettype none

package cpspc_pkg;

    // Fixed-point setup.
    localparam int GAIN_FRAC_BITS   = 12;
    localparam int INTEGRATOR_WIDTH = 24;

    // Field widths.
    localparam int MODE_W      = 2;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 9;
    localparam int DUTY_W      = 8;
    localparam int SPEED_W     = 10;
    localparam int POS_W       = 32;
    localparam int DRIVE_W     = 8;
    localparam int ERR_W       = SPEED_W + 1;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Shared multiplier: unsigned gain (one zero bit added) times a signed operand.
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = POS_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SETP_W  = PROD_W - GAIN_FRAC_BITS;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2 ** (GAIN_FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0]  U_TOP = SUM_W'(127 * (2 ** GAIN_FRAC_BITS));
    localparam logic signed [SUM_W-1:0]  U_BOT = SUM_W'(-128 * (2 ** GAIN_FRAC_BITS));

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'h7F;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 8'h80;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  RST_POS_GAIN    = 16'd1229;
    localparam logic [GAIN_W-1:0]  RST_SPEED_GAIN  = 16'd4915;
    localparam logic [GAIN_W-1:0]  RST_INT_GAIN    = 16'd74;
    localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT = 9'd511;
    localparam logic [DUTY_W-1:0]  RST_MANUAL_LOW  = 8'd0;
    localparam logic [DUTY_W-1:0]  RST_MANUAL_HIGH = 8'd255;

    typedef enum logic [MODE_W-1:0] {
        MODE_POSITION = 2'd0,
        MODE_SPEED    = 2'd1,
        MODE_MANUAL   = 2'd2,
        MODE_HOLD     = 2'd3
    } t_mode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE          = 3'd0,
        CFG_POSITION_GAIN = 3'd1,
        CFG_SPEED_GAIN    = 3'd2,
        CFG_INTEGRAL_GAIN = 3'd3,
        CFG_SPEED_LIMIT   = 3'd4,
        CFG_MANUAL_LOW    = 3'd5,
        CFG_MANUAL_HIGH   = 3'd6
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PERR,
        S_PMUL,
        S_PROUND,
        S_CMD,
        S_ERR,
        S_IMUL,
        S_IACC,
        S_SMUL,
        S_DRIVE,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        MUL_POS,
        MUL_INT,
        MUL_SPEED
    } t_mul_src;

    // Saturates a wide sum to the signed integrator range.
    function automatic logic signed [INTEGRATOR_WIDTH-1:0] sat_integ(
        input logic signed [SUM_W-1:0] x
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [INTEGRATOR_WIDTH-1:0] r;
        hi = {{(SUM_W - INTEGRATOR_WIDTH + 1){1'b0}}, {(INTEGRATOR_WIDTH - 1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            r = hi[INTEGRATOR_WIDTH-1:0];
        end else if (x < lo) begin
            r = lo[INTEGRATOR_WIDTH-1:0];
        end else begin
            r = x[INTEGRATOR_WIDTH-1:0];
        end
        return r;
    endfunction

    localparam logic signed [INTEGRATOR_WIDTH-1:0] INTEG_TOP = sat_integ(U_TOP);
    localparam logic signed [INTEGRATOR_WIDTH-1:0] INTEG_BOT = sat_integ(U_BOT);

endpackage

`default_nettype wire

// ----- rtl/core/cascaded_position_speed_pi_control_unit.sv -----
// Cascaded position / speed PI control unit: top level with sequencer and datapath.
// Depends on cpspc_pkg and cascaded_position_speed_pi_control_unit_assert.svh.
`default_nettype none

// One control sample per input word, one result word per sample. A small sequencer drives
// a single shared 17x32 signed multiplier, which is used for the position P term, the
// integral term and the speed P term in turn; that multiplier and the steps around it set
// the pace. Position mode runs position error, P product, rounding, speed command, speed
// error, I product, I sum, speed product, drive and finish; speed mode starts at speed
// command, manual and hold go to finish. The input is not ready while a sample is in work.
// The result sits in an output register, so a new sample may start while the previous
// result waits; the sequencer only stalls at its last step if that register is still full.
// Configuration writes take effect at once and are meant for times when the unit is idle.
`include "cascaded_position_speed_pi_control_unit_assert.svh"

module cascaded_position_speed_pi_control_unit (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    // Configuration write port
    input  wire logic                                     i_cfg_we,
    input  wire logic [cpspc_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  wire logic [cpspc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // Input channel
    input  wire logic                                     i_valid,
    output logic                                          o_ready,
    input  wire logic signed [cpspc_pkg::SPEED_W-1:0]     i_measured_speed,
    input  wire logic signed [cpspc_pkg::POS_W-1:0]       i_position_now,
    input  wire logic signed [cpspc_pkg::POS_W-1:0]       i_position_target,
    input  wire logic signed [cpspc_pkg::SPEED_W-1:0]     i_speed_target,
    input  wire logic [cpspc_pkg::DUTY_W-1:0]             i_manual_duty,
    // Output channel
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output logic [cpspc_pkg::DUTY_W-1:0]                  o_pwm_duty,
    output logic signed [cpspc_pkg::DRIVE_W-1:0]          o_drive_value,
    output logic signed [cpspc_pkg::SPEED_W-1:0]          o_speed_command,
    output logic signed [cpspc_pkg::ERR_W-1:0]            o_speed_error,
    output logic signed [cpspc_pkg::POS_W-1:0]            o_position_error
);

    // Configuration registers
    cpspc_pkg::t_mode                     r_mode;
    logic [cpspc_pkg::GAIN_W-1:0]         r_pos_gain;
    logic [cpspc_pkg::GAIN_W-1:0]         r_speed_gain;
    logic [cpspc_pkg::GAIN_W-1:0]         r_int_gain;
    logic [cpspc_pkg::LIMIT_W-1:0]        r_speed_limit;
    logic [cpspc_pkg::DUTY_W-1:0]         r_manual_low;
    logic [cpspc_pkg::DUTY_W-1:0]         r_manual_high;

    // Sequencer
    cpspc_pkg::t_state                    r_state;
    cpspc_pkg::t_state                    n_state;

    // Captured input word
    logic signed [cpspc_pkg::SPEED_W-1:0] r_meas;
    logic signed [cpspc_pkg::POS_W-1:0]   r_pnow;
    logic signed [cpspc_pkg::POS_W-1:0]   r_ptgt;
    logic [cpspc_pkg::DUTY_W-1:0]         r_mduty;

    // Datapath registers
    logic signed [cpspc_pkg::POS_W-1:0]            r_perr;
    logic signed [cpspc_pkg::PROD_W-1:0]           r_prod;
    logic signed [cpspc_pkg::SETP_W-1:0]           r_setp;
    logic signed [cpspc_pkg::SPEED_W-1:0]          r_cmd;
    logic signed [cpspc_pkg::ERR_W-1:0]            r_err;
    logic signed [cpspc_pkg::INTEGRATOR_WIDTH-1:0] r_integ;
    logic signed [cpspc_pkg::DRIVE_W-1:0]          r_last_drive;

    // Output register
    logic                                 r_out_valid;
    logic [cpspc_pkg::DUTY_W-1:0]         r_pwm;
    logic signed [cpspc_pkg::DRIVE_W-1:0] r_drive;
    logic signed [cpspc_pkg::SPEED_W-1:0] r_cmd_out;
    logic signed [cpspc_pkg::ERR_W-1:0]   r_err_out;
    logic signed [cpspc_pkg::POS_W-1:0]   r_perr_out;

    // Sequencer controls
    logic                  c_ready;
    logic                  c_load_perr;
    logic                  c_mul_en;
    cpspc_pkg::t_mul_src   c_mul_src;
    logic                  c_round;
    logic                  c_load_cmd;
    logic                  c_load_err;
    logic                  c_integ_acc;
    logic                  c_drive_step;
    logic                  c_fin;

    logic                  in_take;
    logic                  out_free;

    // Combinational datapath values
    logic signed [cpspc_pkg::POS_W:0]              perr_diff;
    logic signed [cpspc_pkg::POS_W-1:0]            n_perr;
    logic signed [cpspc_pkg::MUL_A_W-1:0]          mul_a;
    logic signed [cpspc_pkg::MUL_B_W-1:0]          mul_b;
    logic signed [cpspc_pkg::PROD_W-1:0]           mul_p;
    logic signed [cpspc_pkg::PROD_W-1:0]           rnd_sum;
    logic signed [cpspc_pkg::PROD_W-1:0]           rnd_shift;
    logic signed [cpspc_pkg::SETP_W-1:0]           lim_pos;
    logic signed [cpspc_pkg::SETP_W-1:0]           lim_neg;
    logic signed [cpspc_pkg::SPEED_W-1:0]          n_cmd;
    logic signed [cpspc_pkg::SUM_W-1:0]            integ_sum;
    logic signed [cpspc_pkg::SUM_W-1:0]            u_sum;
    logic signed [cpspc_pkg::SUM_W-1:0]            u_shift;
    logic [cpspc_pkg::DUTY_W-1:0]                  duty_raised;
    logic [cpspc_pkg::DUTY_W-1:0]                  duty_manual;
    logic                                          mode_ctrl;

    assign in_take   = i_valid && c_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign mode_ctrl = (r_mode == cpspc_pkg::MODE_POSITION) || (r_mode == cpspc_pkg::MODE_SPEED);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpspc_pkg::S_IDLE: begin
                if (in_take) begin
                    case (r_mode)
                        cpspc_pkg::MODE_POSITION: n_state = cpspc_pkg::S_PERR;
                        cpspc_pkg::MODE_SPEED:    n_state = cpspc_pkg::S_CMD;
                        default:                  n_state = cpspc_pkg::S_FIN;
                    endcase
                end
            end
            cpspc_pkg::S_PERR:   n_state = cpspc_pkg::S_PMUL;
            cpspc_pkg::S_PMUL:   n_state = cpspc_pkg::S_PROUND;
            cpspc_pkg::S_PROUND: n_state = cpspc_pkg::S_CMD;
            cpspc_pkg::S_CMD:    n_state = cpspc_pkg::S_ERR;
            cpspc_pkg::S_ERR:    n_state = cpspc_pkg::S_IMUL;
            cpspc_pkg::S_IMUL:   n_state = cpspc_pkg::S_IACC;
            cpspc_pkg::S_IACC:   n_state = cpspc_pkg::S_SMUL;
            cpspc_pkg::S_SMUL:   n_state = cpspc_pkg::S_DRIVE;
            cpspc_pkg::S_DRIVE:  n_state = cpspc_pkg::S_FIN;
            cpspc_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = cpspc_pkg::S_IDLE;
                end
            end
            default:             n_state = cpspc_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        c_ready      = 1'b0;
        c_load_perr  = 1'b0;
        c_mul_en     = 1'b0;
        c_mul_src    = cpspc_pkg::MUL_POS;
        c_round      = 1'b0;
        c_load_cmd   = 1'b0;
        c_load_err   = 1'b0;
        c_integ_acc  = 1'b0;
        c_drive_step = 1'b0;
        c_fin        = 1'b0;
        case (r_state)
            cpspc_pkg::S_IDLE:   c_ready = 1'b1;
            cpspc_pkg::S_PERR:   c_load_perr = 1'b1;
            cpspc_pkg::S_PMUL: begin
                c_mul_en  = 1'b1;
                c_mul_src = cpspc_pkg::MUL_POS;
            end
            cpspc_pkg::S_PROUND: c_round = 1'b1;
            cpspc_pkg::S_CMD:    c_load_cmd = 1'b1;
            cpspc_pkg::S_ERR:    c_load_err = 1'b1;
            cpspc_pkg::S_IMUL: begin
                c_mul_en  = 1'b1;
                c_mul_src = cpspc_pkg::MUL_INT;
            end
            cpspc_pkg::S_IACC:   c_integ_acc = 1'b1;
            cpspc_pkg::S_SMUL: begin
                c_mul_en  = 1'b1;
                c_mul_src = cpspc_pkg::MUL_SPEED;
            end
            cpspc_pkg::S_DRIVE:  c_drive_step = 1'b1;
            cpspc_pkg::S_FIN:    c_fin = out_free;
            default:             c_ready = 1'b0;
        endcase
    end

    assign o_ready = c_ready;

    // Position error, saturated to 32 bits when the difference overflows.
    assign perr_diff = {r_ptgt[cpspc_pkg::POS_W-1], r_ptgt} - {r_pnow[cpspc_pkg::POS_W-1], r_pnow};
    always_comb begin
        if (perr_diff[cpspc_pkg::POS_W] != perr_diff[cpspc_pkg::POS_W-1]) begin
            n_perr = perr_diff[cpspc_pkg::POS_W] ?
                     {1'b1, {(cpspc_pkg::POS_W - 1){1'b0}}} :
                     {1'b0, {(cpspc_pkg::POS_W - 1){1'b1}}};
        end else begin
            n_perr = perr_diff[cpspc_pkg::POS_W-1:0];
        end
    end

    // Shared multiplier operands.
    always_comb begin
        case (c_mul_src)
            cpspc_pkg::MUL_POS: begin
                mul_a = {1'b0, r_pos_gain};
                mul_b = r_perr;
            end
            cpspc_pkg::MUL_INT: begin
                mul_a = {1'b0, r_int_gain};
                mul_b = cpspc_pkg::MUL_B_W'(r_err);
            end
            cpspc_pkg::MUL_SPEED: begin
                mul_a = {1'b0, r_speed_gain};
                mul_b = cpspc_pkg::MUL_B_W'(r_err);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round to nearest, ties up, then drop the fraction bits.
    assign rnd_sum   = r_prod + cpspc_pkg::ROUND_HALF;
    assign rnd_shift = rnd_sum >>> cpspc_pkg::GAIN_FRAC_BITS;

    // Speed setpoint clamp to the symmetric limit.
    assign lim_pos = {{(cpspc_pkg::SETP_W - cpspc_pkg::LIMIT_W){1'b0}}, r_speed_limit};
    assign lim_neg = -lim_pos;
    always_comb begin
        if (r_setp > lim_pos) begin
            n_cmd = lim_pos[cpspc_pkg::SPEED_W-1:0];
        end else if (r_setp < lim_neg) begin
            n_cmd = lim_neg[cpspc_pkg::SPEED_W-1:0];
        end else begin
            n_cmd = r_setp[cpspc_pkg::SPEED_W-1:0];
        end
    end

    assign integ_sum = cpspc_pkg::SUM_W'(r_integ) + cpspc_pkg::SUM_W'(r_prod);
    assign u_sum     = cpspc_pkg::SUM_W'(r_prod) + cpspc_pkg::SUM_W'(r_integ);
    assign u_shift   = u_sum >>> cpspc_pkg::GAIN_FRAC_BITS;

    // Manual duty: raise to the low limit first, then the high limit wins.
    assign duty_raised = (r_mduty < r_manual_low) ? r_manual_low : r_mduty;
    assign duty_manual = (duty_raised > r_manual_high) ? r_manual_high : duty_raised;

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= cpspc_pkg::S_IDLE;
            r_mode        <= cpspc_pkg::MODE_SPEED;
            r_pos_gain    <= cpspc_pkg::RST_POS_GAIN;
            r_speed_gain  <= cpspc_pkg::RST_SPEED_GAIN;
            r_int_gain    <= cpspc_pkg::RST_INT_GAIN;
            r_speed_limit <= cpspc_pkg::RST_SPEED_LIMIT;
            r_manual_low  <= cpspc_pkg::RST_MANUAL_LOW;
            r_manual_high <= cpspc_pkg::RST_MANUAL_HIGH;
            r_integ       <= '0;
            r_last_drive  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (cpspc_pkg::t_cfg_index'(i_cfg_index))
                    cpspc_pkg::CFG_MODE:
                        r_mode <= cpspc_pkg::t_mode'(i_cfg_data[cpspc_pkg::MODE_W-1:0]);
                    cpspc_pkg::CFG_POSITION_GAIN: r_pos_gain <= i_cfg_data;
                    cpspc_pkg::CFG_SPEED_GAIN:    r_speed_gain <= i_cfg_data;
                    cpspc_pkg::CFG_INTEGRAL_GAIN: r_int_gain <= i_cfg_data;
                    cpspc_pkg::CFG_SPEED_LIMIT:
                        r_speed_limit <= i_cfg_data[cpspc_pkg::LIMIT_W-1:0];
                    cpspc_pkg::CFG_MANUAL_LOW:
                        r_manual_low <= i_cfg_data[cpspc_pkg::DUTY_W-1:0];
                    cpspc_pkg::CFG_MANUAL_HIGH:
                        r_manual_high <= i_cfg_data[cpspc_pkg::DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (c_integ_acc) begin
                r_integ <= cpspc_pkg::sat_integ(integ_sum);
            end
            // Anti-windup: when the output clamps, the integrator is pinned to the clamp.
            if (c_drive_step) begin
                if (u_sum > cpspc_pkg::U_TOP) begin
                    r_last_drive <= cpspc_pkg::DRIVE_MAX;
                    r_integ      <= cpspc_pkg::INTEG_TOP;
                end else if (u_sum < cpspc_pkg::U_BOT) begin
                    r_last_drive <= cpspc_pkg::DRIVE_MIN;
                    r_integ      <= cpspc_pkg::INTEG_BOT;
                end else begin
                    r_last_drive <= u_shift[cpspc_pkg::DRIVE_W-1:0];
                end
            end
            if (c_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_meas  <= i_measured_speed;
            r_pnow  <= i_position_now;
            r_ptgt  <= i_position_target;
            r_mduty <= i_manual_duty;
            r_setp  <= cpspc_pkg::SETP_W'(i_speed_target);
        end else if (c_round) begin
            r_setp <= rnd_shift[cpspc_pkg::SETP_W-1:0];
        end
        if (c_load_perr) begin
            r_perr <= n_perr;
        end
        if (c_mul_en) begin
            r_prod <= mul_p;
        end
        if (c_load_cmd) begin
            r_cmd <= n_cmd;
        end
        if (c_load_err) begin
            r_err <= cpspc_pkg::ERR_W'(r_cmd) - cpspc_pkg::ERR_W'(r_meas);
        end
        if (c_fin) begin
            r_drive <= r_last_drive;
            // Outside manual mode the duty is the drive value offset by 128, i.e. its sign bit inverted.
            r_pwm   <= (r_mode == cpspc_pkg::MODE_MANUAL) ? duty_manual :
                       {~r_last_drive[cpspc_pkg::DRIVE_W-1], r_last_drive[cpspc_pkg::DRIVE_W-2:0]};
            r_cmd_out  <= mode_ctrl ? r_cmd : '0;
            r_err_out  <= mode_ctrl ? r_err : '0;
            r_perr_out <= (r_mode == cpspc_pkg::MODE_POSITION) ? r_perr : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_pwm_duty       = r_pwm;
    assign o_drive_value    = r_drive;
    assign o_speed_command  = r_cmd_out;
    assign o_speed_error    = r_err_out;
    assign o_position_error = r_perr_out;

    // Checks
    `CPSPC_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready after accept")
    `CPSPC_ASSERT_NOW(a_manual_holds_integ,
        (r_state == cpspc_pkg::S_FIN) && (r_mode == cpspc_pkg::MODE_MANUAL),
        $stable(r_integ), "integrator moved in manual mode")
    `CPSPC_ASSERT_NOW(a_manual_duty_bounds,
        r_out_valid && (r_mode == cpspc_pkg::MODE_MANUAL) && (r_manual_low <= r_manual_high),
        (o_pwm_duty >= r_manual_low) && (o_pwm_duty <= r_manual_high),
        "manual duty outside limits")

endmodule

`default_nettype wire
